>>> rtl/isots_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// isots_pkg
// Shared types, constants and helper functions of the timestamp parser.
// ---------------------------------------------------------------------------
package isots_pkg;

    // Result width and output bus width (whole bytes).
    localparam int MS_W       = 49;
    localparam int OUT_DATA_W = 56;

    // Default depth of the record queue between the parser and the date unit.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Configuration register indexes.
    localparam logic [0:0] REG_MIN_TIME = 1'b0;
    localparam logic [0:0] REG_MAX_TIME = 1'b1;

    // Reset values of the window registers.
    localparam logic signed [MS_W-1:0] MIN_TIME_RST = -49'sd62167219200000;
    localparam logic signed [MS_W-1:0] MAX_TIME_RST = 49'sd253402300799000;

    // Date arithmetic constants.
    localparam logic signed [18:0] ERA_DAYS     = 19'sd146097;
    localparam logic signed [24:0] EPOCH_SHIFT  = 25'sd719468;
    localparam logic signed [17:0] DAY_SEC      = 18'sd86400;
    localparam logic signed [15:0] ERA_YEARS    = 16'sd400;
    localparam logic [12:0]        DIV400_RECIP = 13'd5243;
    localparam logic [5:0]         DIV100_RECIP = 6'd41;
    localparam logic [8:0]         YEAR_DAYS    = 9'd365;
    localparam logic [11:0]        HOUR_SEC     = 12'd3600;
    localparam logic [5:0]         MIN_SEC      = 6'd60;

    // One parsed timestamp, handed from the parser to the date unit.
    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } isots_rec_t;

    // Days before the first of a month in a year that starts in March.
    function automatic logic [8:0] month_offset(input logic [3:0] month);
        logic [8:0] off;
        begin
            unique case (month)
                4'd3:    off = 9'd0;
                4'd4:    off = 9'd31;
                4'd5:    off = 9'd61;
                4'd6:    off = 9'd92;
                4'd7:    off = 9'd122;
                4'd8:    off = 9'd153;
                4'd9:    off = 9'd184;
                4'd10:   off = 9'd214;
                4'd11:   off = 9'd245;
                4'd12:   off = 9'd275;
                4'd1:    off = 9'd306;
                4'd2:    off = 9'd337;
                default: off = 9'd0;
            endcase
            return off;
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/isots_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// isots_front
// Character parser: checks each character against its position, gathers the
// date and time digits and pushes one record per text into the queue.
// ---------------------------------------------------------------------------
module isots_front
    import isots_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] text_char
    input  wire logic       s_axis_tlast,   // last_char
    input  wire logic       q_full,
    output logic            q_push,
    output isots_rec_t      q_rec
);

    localparam logic [4:0] TEXT_LEN   = 5'd20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_Z     = 8'h5A;

    logic [4:0]  pos_reg, pos_next;
    logic        good_reg, good_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;

    logic       accept;
    logic       is_sep;
    logic [7:0] sep_char;
    logic       is_digit;
    logic [3:0] digit;
    logic       rec_ok;

    function automatic logic [6:0] push7(input logic [6:0] acc, input logic [3:0] d);
        return 7'({acc, 3'b000} + {acc, 1'b0} + {3'b000, d});
    endfunction

    function automatic logic [13:0] push14(input logic [13:0] acc, input logic [3:0] d);
        return 14'({acc, 3'b000} + {acc, 1'b0} + {10'b0, d});
    endfunction

    // The queue takes a record in any cycle it has room.
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Separator expected at this position, if any.
    always_comb
    begin
        is_sep   = 1'b1;
        sep_char = CHAR_DASH;
        unique case (pos_reg)
            5'd4, 5'd7:   sep_char = CHAR_DASH;
            5'd10:        sep_char = CHAR_T;
            5'd13, 5'd16: sep_char = CHAR_COLON;
            5'd19:        sep_char = CHAR_Z;
            default:      is_sep   = 1'b0;
        endcase
    end

    assign is_digit = (s_axis_tdata >= CHAR_ZERO) && (s_axis_tdata <= CHAR_NINE);
    assign digit    = 4'(s_axis_tdata - CHAR_ZERO);

    // Position check and digit accumulation for the current character.
    always_comb
    begin
        pos_next    = pos_reg;
        good_next   = good_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        if (pos_reg < TEXT_LEN)
        begin
            pos_next = 5'(pos_reg + 5'd1);
            if (is_sep)
            begin
                if (s_axis_tdata != sep_char)
                    good_next = 1'b0;
            end
            else if (!is_digit)
                good_next = 1'b0;
            else if (pos_reg < 5'd4)
                year_next = push14(year_reg, digit);
            else if (pos_reg < 5'd7)
                month_next = push7(month_reg, digit);
            else if (pos_reg < 5'd10)
                day_next = push7(day_reg, digit);
            else if (pos_reg < 5'd13)
                hour_next = push7(hour_reg, digit);
            else if (pos_reg < 5'd16)
                minute_next = push7(minute_reg, digit);
            else
                second_next = push7(second_reg, digit);
        end
        else
            good_next = 1'b0;
    end

    // Length, format and field range verdict for a text ending here.
    assign rec_ok = (pos_reg == 5'(TEXT_LEN - 5'd1)) && good_next
                 && (month_next >= 7'd1) && (month_next <= 7'd12)
                 && (day_next >= 7'd1) && (day_next <= 7'd31)
                 && (hour_next <= 7'd23) && (minute_next <= 7'd59)
                 && (second_next <= 7'd60);

    // Record handed to the date unit; a leap second reads as 59.
    always_comb
    begin
        q_rec.ok     = rec_ok;
        q_rec.year   = year_next;
        q_rec.month  = month_next[3:0];
        q_rec.day    = day_next[4:0];
        q_rec.hour   = hour_next[4:0];
        q_rec.minute = minute_next[5:0];
        q_rec.second = (second_next > 7'd59) ? 6'd59 : second_next[5:0];
    end

    assign q_push = accept && s_axis_tlast;

    // Parser state; a last character starts the next text afresh.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            good_reg   <= 1'b1;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
        end
        else if (accept)
        begin
            if (s_axis_tlast)
            begin
                pos_reg    <= '0;
                good_reg   <= 1'b1;
                year_reg   <= '0;
                month_reg  <= '0;
                day_reg    <= '0;
                hour_reg   <= '0;
                minute_reg <= '0;
                second_reg <= '0;
            end
            else
            begin
                pos_reg    <= pos_next;
                good_reg   <= good_next;
                year_reg   <= year_next;
                month_reg  <= month_next;
                day_reg    <= day_next;
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
                second_reg <= second_next;
            end
        end
    end

    // The position counter saturates at the text length.
    assert property (@(posedge clk) disable iff (!rst_n) pos_reg <= TEXT_LEN)
        else $error("position counter ran past the text length");

    // A record is only pushed while the queue has room.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("record pushed into a full queue");

endmodule
`default_nettype wire

>>> rtl/isots_fifo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// isots_fifo
// Short record queue between the parser and the date unit.
// ---------------------------------------------------------------------------
module isots_fifo
    import isots_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire isots_rec_t  push_rec,
    input  wire logic        pop,
    output isots_rec_t       head_rec,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    isots_rec_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_rec = slot_reg[rd_ptr_reg];

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
            if (do_push && !do_pop)
                count_reg <= CNT_W'(count_reg + 1'b1);
            else if (do_pop && !do_push)
                count_reg <= CNT_W'(count_reg - 1'b1);
        end
    end

endmodule
`default_nettype wire

>>> rtl/isots_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// isots_back
// Date unit: turns one parsed record into Unix milliseconds over a short
// sequence of steps, checks the window and holds the result for the output.
// ---------------------------------------------------------------------------
module isots_back
    import isots_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire isots_rec_t             rec,
    input  wire logic                   rec_valid,
    output logic                        rec_pop,
    input  wire logic signed [MS_W-1:0] min_time_ms,
    input  wire logic signed [MS_W-1:0] max_time_ms,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]       m_axis_tdata,  // [48:0] epoch_ms, rest zero
    output logic                        m_axis_tuser   // parse_ok
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERA,
        ST_YOE,
        ST_DOE,
        ST_DAYS,
        ST_SEC,
        ST_MS,
        ST_WIN,
        ST_OUT
    } state_t;

    state_t                  state_reg;
    isots_rec_t              rec_reg;
    logic                    out_valid_reg;
    logic                    out_ok_reg;
    logic signed [MS_W-1:0]  out_ms_reg;

    logic signed [14:0]      y_reg, y_next;
    logic signed [5:0]       era_reg, era_next;
    logic [8:0]              yoe_reg, yoe_next;
    logic [8:0]              doy_reg, doy_next;
    logic [17:0]             doe_reg, doe_next;
    logic signed [22:0]      days_reg, days_next;
    logic signed [38:0]      secs_reg, secs_next;
    logic signed [MS_W-1:0]  ms_reg, ms_next;

    logic [26:0]             era_prod;
    logic signed [15:0]      yoe_full;
    logic [14:0]             q100_prod;
    logic signed [24:0]      era_days;
    logic signed [24:0]      days_full;
    logic [16:0]             tod_sec;
    logic                    in_window;
    logic                    out_free;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign rec_pop  = (state_reg == ST_IDLE) && rec_valid;

    // Year shifted to a March start and its 400-year era.
    always_comb
    begin
        y_next   = 15'($signed({1'b0, rec_reg.year}) - ((rec_reg.month <= 4'd2) ? 15'sd1 : 15'sd0));
        era_prod = 27'(y_reg[13:0] * DIV400_RECIP);
        era_next = y_reg[14] ? -6'sd1 : $signed(era_prod[26:21]);
    end

    // Year of era and day of the March-based year.
    always_comb
    begin
        yoe_full = 16'(y_reg - era_reg * ERA_YEARS);
        yoe_next = yoe_full[8:0];
        doy_next = 9'(month_offset(rec_reg.month) + {4'b0, rec_reg.day} - 9'd1);
    end

    // Day of era.
    always_comb
    begin
        q100_prod = 15'(yoe_reg * DIV100_RECIP);
        doe_next  = 18'(yoe_reg * YEAR_DAYS) + 18'(yoe_reg >> 2)
                  - 18'(q100_prod[14:12]) + 18'(doy_reg);
    end

    // Days since the epoch.
    always_comb
    begin
        era_days  = 25'(era_reg * ERA_DAYS);
        days_full = era_days + $signed({7'b0, doe_reg}) - EPOCH_SHIFT;
        days_next = days_full[22:0];
    end

    // Seconds since the epoch.
    always_comb
    begin
        tod_sec   = 17'(rec_reg.hour * HOUR_SEC) + 17'(rec_reg.minute * MIN_SEC)
                  + 17'(rec_reg.second);
        secs_next = 39'(days_reg * DAY_SEC) + $signed({22'b0, tod_sec});
    end

    // Milliseconds: times 1000 as 1024 - 16 - 8.
    always_comb
    begin
        ms_next = MS_W'({{(MS_W-39){secs_reg[38]}}, secs_reg} <<< 10)
                - MS_W'({{(MS_W-39){secs_reg[38]}}, secs_reg} <<< 4)
                - MS_W'({{(MS_W-39){secs_reg[38]}}, secs_reg} <<< 3);
    end

    assign in_window = (ms_reg >= min_time_ms) && (ms_reg <= max_time_ms);

    // Arithmetic stage registers.
    always_ff @(posedge clk)
    begin
        if (rec_pop)
            rec_reg <= rec;
        unique case (state_reg)
            ST_ERA:
            begin
                y_reg <= y_next;
            end
            ST_YOE:
            begin
                era_reg <= era_next;
            end
            ST_DOE:
            begin
                yoe_reg <= yoe_next;
                doy_reg <= doy_next;
            end
            ST_DAYS:
            begin
                doe_reg <= doe_next;
            end
            ST_SEC:
            begin
                days_reg <= days_next;
            end
            ST_MS:
            begin
                secs_reg <= secs_next;
            end
            ST_WIN:
            begin
                ms_reg <= ms_next;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_ms_reg    <= '0;
        end
        else
        begin
            // A taken word frees the output unless a new one is loaded now.
            if (out_valid_reg && m_axis_tready && (state_reg != ST_OUT))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (rec_valid) state_reg <= ST_ERA;
                ST_ERA:  state_reg <= ST_YOE;
                ST_YOE:  state_reg <= ST_DOE;
                ST_DOE:  state_reg <= ST_DAYS;
                ST_DAYS: state_reg <= ST_SEC;
                ST_SEC:  state_reg <= ST_MS;
                ST_MS:   state_reg <= ST_WIN;
                ST_WIN:  state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_ok_reg    <= rec_reg.ok && in_window;
                        out_ms_reg    <= (rec_reg.ok && in_window) ? ms_reg : '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_ok_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-MS_W){1'b0}}, out_ms_reg};

    // A refused text always reports zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> (out_ms_reg == '0))
        else $error("refused result carries a nonzero time");

    // An accepted result lies inside the configured window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ok_reg) |->
        ((out_ms_reg >= min_time_ms) && (out_ms_reg <= max_time_ms)))
        else $error("accepted result outside the window");

    // A finished result waits while the output register is still occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_valid_reg && !m_axis_tready) |=> (state_reg == ST_OUT))
        else $error("result overwrote an untaken output");

    // A record is only taken while the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        rec_pop |-> (state_reg == ST_IDLE))
        else $error("record taken mid-sequence");

endmodule
`default_nettype wire

>>> rtl/iso_timestamp_to_epoch_ms_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// iso_timestamp_to_epoch_ms_top
// Parses UTC timestamps of the form YYYY-MM-DDTHH:MM:SSZ, one character per
// word, and returns the Unix time in milliseconds with a valid flag.
//
//   Channel   Direction  Payload                          Word
//   s_axis    in         tdata[7:0] char, tlast end mark  one character
//   m_axis    out        tdata[48:0] ms, tuser ok flag    one result
//   cfg       in         index 0 min_time_ms, 1 max       one register write
//
// The parser takes one character per cycle; a text is 20 characters. The date
// unit takes a record only when idle and handles it in one pass of its step
// sequencer. The record queue lets the parser run on while the date unit
// works or the output stalls; the input stalls only when the queue is full.
// Reset clears the parser, the queue and the output, and restores the window.
// ---------------------------------------------------------------------------
module iso_timestamp_to_epoch_ms_top
    import isots_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] text_char
    input  wire logic                  s_axis_tlast,   // last_char
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [48:0] epoch_ms, rest zero
    output logic                       m_axis_tuser,   // parse_ok
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [0:0]            cfg_index,
    input  wire logic [MS_W-1:0]       cfg_data
);

    logic signed [MS_W-1:0] min_time_reg;
    logic signed [MS_W-1:0] max_time_reg;
    isots_rec_t             push_rec;
    isots_rec_t             head_rec;
    logic                   q_push;
    logic                   q_pop;
    logic                   q_full;
    logic                   q_empty;

    // Window registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_time_reg <= MIN_TIME_RST;
            max_time_reg <= MAX_TIME_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MIN_TIME: min_time_reg <= $signed(cfg_data);
                REG_MAX_TIME: max_time_reg <= $signed(cfg_data);
                default:      ;
            endcase
        end
    end

    isots_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_rec         (push_rec)
    );

    isots_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (push_rec),
        .pop      (q_pop),
        .head_rec (head_rec),
        .full     (q_full),
        .empty    (q_empty)
    );

    isots_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec           (head_rec),
        .rec_valid     (!q_empty),
        .rec_pop       (q_pop),
        .min_time_ms   (min_time_reg),
        .max_time_ms   (max_time_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire
